@@ rtl/ipv4_endpoint_text_validator_core_assert.svh @@
// ----------------------------------------------------------------------------
// IPv4 endpoint text validator assertion macros
// Clocked assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef IPV4_ENDPOINT_TEXT_VALIDATOR_CORE_ASSERT_SVH
`define IPV4_ENDPOINT_TEXT_VALIDATOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check prop on every rising edge outside reset.
`define ETV_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ipv4_etv assertion failed");
// Check prop on every rising edge, reset included.
`define ETV_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ipv4_etv assertion failed");
`else
`define ETV_ASSERT(label, clk, rst, prop)
`define ETV_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/ipv4_etv_pkg.sv @@
// ----------------------------------------------------------------------------
// IPv4 endpoint text validator package
// Character codes, limits and the result record shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipv4_etv_pkg;

  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [7:0]  CHAR_DOT   = 8'h2E;
  localparam logic [7:0]  CHAR_COLON = 8'h3A;

  localparam int unsigned ACCUM_W    = 17;
  localparam logic [ACCUM_W-1:0] OCTET_MAX = 17'd255;
  localparam logic [2:0]  MAX_DIGITS = 3'd5;
  localparam logic [2:0]  LAST_OCTET = 3'd3;
  localparam logic [2:0]  PORT_PART  = 3'd4;

  typedef struct packed {
    logic            is_valid;
    logic [15:0]     port;
    logic [3:0][7:0] octet;   // octet[0] is the first octet
  } result_t;

endpackage

@@ rtl/ipv4_etv_parse.sv @@
// ----------------------------------------------------------------------------
// IPv4 endpoint text validator parser
// Per-character state update and end-of-string result, one character a cycle while take is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ipv4_endpoint_text_validator_core_assert.svh"

module ipv4_etv_parse
  import ipv4_etv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,        // a character transfer this cycle
  input  logic [7:0] char_in,
  input  logic       last_char,
  output result_t    result       // valid to load when take and last_char
);

  logic [2:0]         part_index, part_index_upd, part_index_next;
  logic [2:0]         digit_count, digit_count_upd, digit_count_next;
  logic [ACCUM_W-1:0] part_accum, part_accum_upd, part_accum_next;
  logic               leading_zero_seen, lz_upd, leading_zero_seen_next;
  logic               error_flag, error_upd, error_flag_next;
  logic [3:0][7:0]    octet_store, store_upd, octet_store_next;

  logic               is_digit, is_dot, is_colon, place_ok, ok;
  logic [ACCUM_W-1:0] digit_val, accum_x10;

  assign is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
  assign is_dot    = (char_in == CHAR_DOT);
  assign is_colon  = (char_in == CHAR_COLON);
  assign digit_val = {{(ACCUM_W-8){1'b0}}, char_in - CHAR_ZERO};
  assign accum_x10 = (part_accum << 3) + (part_accum << 1);
  assign place_ok  = is_colon ? (part_index == LAST_OCTET) : (part_index < LAST_OCTET);

  always_comb begin
    part_index_upd  = part_index;
    digit_count_upd = digit_count;
    part_accum_upd  = part_accum;
    lz_upd          = leading_zero_seen;
    error_upd       = error_flag;
    store_upd       = octet_store;
    if (take && !error_flag) begin
      if (is_digit) begin
        if (digit_count == 3'd0) begin
          part_accum_upd  = digit_val;
          lz_upd          = (digit_val == '0);
          digit_count_upd = 3'd1;
        end else if (leading_zero_seen || digit_count >= MAX_DIGITS) begin
          error_upd = 1'b1;
        end else begin
          part_accum_upd  = accum_x10 + digit_val;
          digit_count_upd = digit_count + 3'd1;
        end
      end else if (is_dot || is_colon) begin
        if (!place_ok || digit_count == 3'd0 || part_accum > OCTET_MAX) begin
          error_upd = 1'b1;
        end else begin
          store_upd[part_index[1:0]] = part_accum[7:0];
          part_index_upd  = part_index + 3'd1;
          digit_count_upd = 3'd0;
          part_accum_upd  = '0;
          lz_upd          = 1'b0;
        end
      end else begin
        error_upd = 1'b1;
      end
    end
  end

  // Port range check is bit 16 clear: five digits never exceed 17 bits.
  assign ok = !error_upd && part_index_upd == PORT_PART && digit_count_upd != 3'd0 &&
              !part_accum_upd[ACCUM_W-1];

  assign result.is_valid = ok;
  assign result.port     = ok ? part_accum_upd[15:0] : 16'd0;
  assign result.octet    = ok ? store_upd : '0;

  // Return to the start state once the string ends.
  always_comb begin
    if (take && last_char) begin
      part_index_next        = '0;
      digit_count_next       = '0;
      part_accum_next        = '0;
      leading_zero_seen_next = 1'b0;
      error_flag_next        = 1'b0;
      octet_store_next       = '0;
    end else begin
      part_index_next        = part_index_upd;
      digit_count_next       = digit_count_upd;
      part_accum_next        = part_accum_upd;
      leading_zero_seen_next = lz_upd;
      error_flag_next        = error_upd;
      octet_store_next       = store_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_index        <= '0;
      digit_count       <= '0;
      part_accum        <= '0;
      leading_zero_seen <= 1'b0;
      error_flag        <= 1'b0;
      octet_store       <= '0;
    end else begin
      part_index        <= part_index_next;
      digit_count       <= digit_count_next;
      part_accum        <= part_accum_next;
      leading_zero_seen <= leading_zero_seen_next;
      error_flag        <= error_flag_next;
      octet_store       <= octet_store_next;
    end
  end

  `ETV_ASSERT(a_part_range, clk, rst, part_index <= PORT_PART && digit_count <= MAX_DIGITS)
  `ETV_ASSERT(a_end_clears, clk, rst, (take && last_char) |=> (part_index == 3'd0 && digit_count == 3'd0 && !error_flag))
  `ETV_ASSERT(a_error_sticky, clk, rst, (error_flag && !(take && last_char)) |=> error_flag)
  `ETV_ASSERT(a_idle_holds, clk, rst, !take |=> ($stable(part_index) && $stable(part_accum)))

endmodule

@@ rtl/ipv4_etv_out_reg.sv @@
// ----------------------------------------------------------------------------
// IPv4 endpoint text validator output register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_etv_out_reg
  import ipv4_etv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  output logic    space,      // a new result may be loaded this cycle
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t dout
);

  assign space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (space) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      dout <= din;
    end
  end

endmodule

@@ rtl/ipv4_endpoint_text_validator_core.sv @@
// ----------------------------------------------------------------------------
// IPv4 endpoint text validator core
// Checks a.b.c.d:port text one character a transfer and reports the values.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one ASCII character per transfer in s_tdata[7:0],
//   s_tlast high on the final character of a string.
//   Output stream (m_*): one result per string, sent for the transfer that
//   carries s_tlast. m_tuser is the valid flag; m_tdata holds the four octets
//   and the port, all zero when the string is invalid.
//   Latency: the result appears on m_tvalid the cycle after the last
//   character transfer.
//   Throughput: one character per cycle while s_tready is high, with the parser
//   (multiply by ten, add and range compare) feeding the output register.
//   Back-pressure: while a result waits with m_tready low, s_tready drops
//   and the parser holds its state; characters that produce no result are
//   still blocked so order is kept simply. Releasing m_tready resumes at once.
//   Reset: rst (synchronous, active high) clears the parser to the start of
//   a string and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_endpoint_text_validator_core
  import ipv4_etv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] octet_a, [15:8] octet_b, [23:16] octet_c,
                                 // [31:24] octet_d, [47:32] port_value
  output logic        m_tuser    // [0] is_valid
);

  logic    take;
  result_t parse_result;
  result_t out_result;

  // Advance the parser on every character transfer.
  assign take = s_tvalid && s_tready;

  ipv4_etv_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_in   (s_tdata),
    .last_char (s_tlast),
    .result    (parse_result)
  );

  // Load a result only on the last character of a string.
  ipv4_etv_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (take && s_tlast),
    .din      (parse_result),
    .space    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dout     (out_result)
  );

  assign m_tdata = {out_result.port, out_result.octet};
  assign m_tuser = out_result.is_valid;

endmodule

@@ verif/ipv4_endpoint_text_validator_core_test.sv @@
// ----------------------------------------------------------------------------
// IPv4 endpoint text validator core testbench
// Streams address strings through the core one character per transfer. A
// cycle-level stream driver and a character-level parser model in this file predict the result of every string.
// Each result transfer is checked field by field against the oldest pending
// prediction. Both stream sides idle at random, with occasional full-rate
// stretches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_endpoint_text_validator_core_test;
  import ipv4_etv_pkg::*;

  localparam int unsigned RANDOM_CHARS = 900;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [ACCUM_W-1:0] PORT_LIMIT = 17'd65535;

  localparam result_t REJECTED = '0;
  localparam result_t ALL_ZERO = '{is_valid: 1'b1, port: 16'h0000, octet: 32'h0000_0000};
  localparam result_t ALL_MAX  = '{is_valid: 1'b1, port: 16'hFFFF, octet: 32'hFFFF_FFFF};

  typedef logic [7:0] char_q_t [$];

  // One directed string; the expected result is only typed in where it is obvious.
  typedef struct {
    string   text;
    bit      known;
    result_t want;
  } dir_row_t;

  dir_row_t dir_rows [$] = '{
    '{"0.0.0.0:0",              1'b1, ALL_ZERO},
    '{"255.255.255.255:65535",  1'b1, ALL_MAX},
    '{"192.168.1.10:8080",      1'b0, REJECTED},
    '{"256.1.1.1:80",           1'b1, REJECTED},  // octet out of range
    '{"1.2.3.4:65536",          1'b1, REJECTED},  // port out of range
    '{"01.2.3.4:5",             1'b1, REJECTED},  // leading zero in octet
    '{"0.0.0.0:00",             1'b1, REJECTED},  // leading zero in port
    '{"1.2.3.4:123456",         1'b1, REJECTED},  // sixth digit
    '{"99999.1.1.1:1",          1'b1, REJECTED},  // five digits, far above 255
    '{"1.2.3.4:99999",          1'b1, REJECTED},
    '{"1.2.3:4",                1'b1, REJECTED},  // colon too early
    '{"1.2.3.4.5:6",            1'b1, REJECTED},  // fourth dot
    '{"1.2.3.4::5",             1'b1, REJECTED},  // second colon
    '{"1..3.4:5",               1'b1, REJECTED},  // empty octet
    '{".1.2.3:4",               1'b1, REJECTED},  // empty first octet
    '{"1.2.3.4",                1'b1, REJECTED},  // no port at all
    '{"1.2.3.4:",               1'b1, REJECTED},  // empty port
    '{"a.2.3.4:5",              1'b1, REJECTED},  // bad character
    '{"1.2.x.4:5",              1'b1, REJECTED},  // later characters are ignored
    '{"1.2.3.4:5 ",             1'b1, REJECTED},  // trailing space
    '{":",                      1'b1, REJECTED},
    '{"7",                      1'b1, REJECTED},
    '{"10.20.30.40:0",          1'b0, REJECTED},  // clean start after errors
    '{"9.8.7.6:5",              1'b0, REJECTED}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tuser;

  // Parser model state
  logic [2:0]         pm_part;
  logic [2:0]         pm_digits;
  logic [ACCUM_W-1:0] pm_value;
  logic               pm_lead_zero;
  logic               pm_error;
  logic [3:0][7:0]    pm_octets;

  result_t     pending_endpoints [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned n_chars;
  int unsigned n_strings;
  int unsigned n_accepted;
  bit          tx_burst;
  bit          rx_burst;

  ipv4_endpoint_text_validator_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void clear_parser();
    pm_part      = '0;
    pm_digits    = '0;
    pm_value     = '0;
    pm_lead_zero = 1'b0;
    pm_error     = 1'b0;
    pm_octets    = '0;
  endfunction

  // Advance the model by one character; returns 1 when the character ends a string.
  function automatic bit parse_char(input logic [7:0] ch, input logic last,
                                    output result_t res);
    logic [3:0] digit;
    bit         place_ok;
    bit         ok;
    res = REJECTED;
    if (!pm_error) begin
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        digit = 4'(ch - CHAR_ZERO);
        if (pm_digits == 0) begin
          pm_value     = ACCUM_W'(digit);
          pm_lead_zero = (digit == 0);
          pm_digits    = 3'd1;
        end else if (pm_lead_zero || pm_digits >= MAX_DIGITS) begin
          pm_error = 1'b1;
        end else begin
          pm_value  = ACCUM_W'(pm_value * 10 + digit);
          pm_digits = pm_digits + 3'd1;
        end
      end else if (ch == CHAR_DOT || ch == CHAR_COLON) begin
        place_ok = (ch == CHAR_COLON) ? (pm_part == LAST_OCTET) : (pm_part < LAST_OCTET);
        if (!place_ok || pm_digits == 0 || pm_value > OCTET_MAX) begin
          pm_error = 1'b1;
        end else begin
          pm_octets[pm_part[1:0]] = pm_value[7:0];
          pm_part      = pm_part + 3'd1;
          pm_digits    = '0;
          pm_value     = '0;
          pm_lead_zero = 1'b0;
        end
      end else begin
        pm_error = 1'b1;
      end
    end
    if (!last) return 1'b0;
    ok = !pm_error && pm_part == PORT_PART && pm_digits != 0 && pm_value <= PORT_LIMIT;
    if (ok) begin
      res.is_valid = 1'b1;
      res.octet    = pm_octets;
      res.port     = pm_value[15:0];
    end
    clear_parser();
    return 1'b1;
  endfunction

  function automatic char_q_t text_to_chars(input string text);
    char_q_t chars;
    for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
    return chars;
  endfunction

  // Bias part values toward zero, the upper limit and single digits; rarely overshoot.
  function automatic int unsigned pick_value(input int unsigned top);
    int unsigned roll;
    roll = $urandom_range(0, 31);
    if (roll < 4) return 0;
    if (roll < 8) return top;
    if (roll < 12) return $urandom_range(0, 9);
    if (roll == 12) return $urandom_range(top + 1, 99999);
    return $urandom_range(0, top);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Drive one string, one character per transfer, tlast on the final character.
  // Entered and left at a falling edge.
  task automatic send_text(input char_q_t chars, input bit known, input result_t want);
    result_t predicted;
    int      gap;
    bit      last;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    foreach (chars[i]) begin
      last = (i == chars.size() - 1);
      gap  = tx_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= chars[i];
      s_tlast  <= last;
      do @(posedge clk); while (!s_tready);
      n_chars++;
      if (parse_char(chars[i], last, predicted))
        pending_endpoints.push_back(known ? want : predicted);
      @(negedge clk);
    end
    n_strings++;
  endtask

  // Result side: random stall before each transfer, then compare with the oldest prediction.
  initial begin : result_sink
    result_t want;
    int      stall;
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if (pending_endpoints.size() == 0) begin
        $error("result transfer with no string pending");
        fail_count++;
      end else begin
        want = pending_endpoints.pop_front();
        if (want.is_valid) n_accepted++;
        check_field("is_valid",   16'(want.is_valid), 16'(m_tuser));
        check_field("octet_a",    16'(want.octet[0]), 16'(m_tdata[7:0]));
        check_field("octet_b",    16'(want.octet[1]), 16'(m_tdata[15:8]));
        check_field("octet_c",    16'(want.octet[2]), 16'(m_tdata[23:16]));
        check_field("octet_d",    16'(want.octet[3]), 16'(m_tdata[31:24]));
        check_field("port_value", want.port,          m_tdata[47:32]);
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    string       syntax_chars;
    char_q_t     chars;
    int unsigned pos;
    int unsigned len;
    int unsigned kind;
    int unsigned random_start;
    syntax_chars = "0123456789.:";
    rst         = 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tlast     <= 1'b0;
    fail_count  = 0;
    n_chars     = 0;
    n_strings   = 0;
    n_accepted  = 0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r])
      send_text(text_to_chars(dir_rows[r].text), dir_rows[r].known, dir_rows[r].want);

    // Mostly well-formed endpoints with random content, mixed with broken ones and noise.
    random_start = n_chars;
    while (n_chars - random_start < RANDOM_CHARS) begin
      chars = text_to_chars($sformatf("%0d.%0d.%0d.%0d:%0d", pick_value(255),
                                      pick_value(255), pick_value(255), pick_value(255),
                                      pick_value(65535)));
      kind = $urandom_range(0, 99);
      if (kind >= 65 && kind < 85) begin
        pos = $urandom_range(0, chars.size() - 1);
        case ($urandom_range(0, 4))
          0: chars.delete(pos);
          1: chars.insert(pos, syntax_chars[$urandom_range(0, 11)]);
          2: chars[pos] = 8'($urandom_range(0, 255));
          3: begin
            len = $urandom_range(1, chars.size() - 1);
            while (chars.size() > len) void'(chars.pop_back());
          end
          default: begin
            // leading zero in front of a part
            if (chars[pos] == CHAR_DOT || chars[pos] == CHAR_COLON)
              chars.insert(pos + 1, CHAR_ZERO);
            else
              chars.insert(0, CHAR_ZERO);
          end
        endcase
      end else if (kind >= 85) begin
        chars.delete();
        len = $urandom_range(1, 14);
        repeat (len) begin
          if ($urandom_range(0, 1))
            chars.push_back(8'($urandom_range(0, 255)));
          else
            chars.push_back(syntax_chars[$urandom_range(0, 11)]);
        end
      end
      send_text(chars, 1'b0, REJECTED);
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (pending_endpoints.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d strings in %0d character transfers; %0d endpoints parsed as valid.",
             n_strings, n_chars, n_accepted);
    $display("Idle gaps 0..8 cycles on both stream sides, with full-rate stretches.");
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
